/* rtl/tts_pkg.sv */
// ----------------------------------------------------------------------------
// tts_pkg
// Shared constants and the token type carried along the slot cell chain.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int TASKS_DEF   = 8;
  localparam int TICK_MS_DEF = 1;

  localparam int MODE_W = 3;
  localparam int SLOT_W = 3;
  localparam int MS_W   = 16;
  localparam int TK_W   = 16;
  localparam int CNT_W  = 32;
  localparam int RUNS_W = 8;

  localparam logic [MODE_W-1:0] MODE_CREATE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_KILL     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TICK     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FINISH   = 3'd4;

  localparam logic [RUNS_W-1:0] RUNS_MAX = 8'hFF;

  // Command token walking from cell to cell; result fields fill in on the way.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              tgt_vld;     // kill, finish, dispatch aim at one slot
    logic [TK_W-1:0]   period_tk;
    logic [TK_W-1:0]   delay_tk;
    logic              claimed;     // create already took a slot
    logic              ok;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  tick_count;
    logic [CNT_W-1:0]  busy;
  } tts_token_t;

endpackage

/* rtl/tts_tick_conv.sv */
// ----------------------------------------------------------------------------
// tts_tick_conv
// Millisecond to tick conversion, rounding up, by reciprocal multiply.
// ----------------------------------------------------------------------------
module tts_tick_conv #(
  parameter int TICK_MS = tts_pkg::TICK_MS_DEF
) (
  input  logic [tts_pkg::MS_W-1:0] ms,
  output logic [tts_pkg::TK_W-1:0] ticks
);

  // Numerator is ms + TICK_MS - 1, below 2^NUM_W. With SH = NUM_W + ceil(log2 T)
  // and MULT = ceil(2^SH / T) the product shifted right by SH is exact.
  localparam int NUM_W  = tts_pkg::MS_W + 1;
  localparam int LOG_T  = $clog2(TICK_MS);
  localparam int SH     = NUM_W + LOG_T;
  localparam int MULT_W = NUM_W + 2;
  localparam longint MULT = ((64'd1 << SH) + longint'(TICK_MS) - 1) / longint'(TICK_MS);
  localparam int PROD_W = NUM_W + MULT_W;

  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] quo;

  assign num   = NUM_W'(ms) + NUM_W'(TICK_MS - 1);
  assign prod  = PROD_W'(num) * PROD_W'(MULT_W'(MULT));
  assign quo   = prod >> SH;
  assign ticks = quo[tts_pkg::TK_W-1:0];

endmodule

/* rtl/tts_cell.sv */
// ----------------------------------------------------------------------------
// tts_cell
// One task slot: holds its state, acts on the passing token, hands it on.
// ----------------------------------------------------------------------------
module tts_cell #(
  parameter int IDX_W = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_vld_i,
  input  tts_pkg::tts_token_t tok_i,
  input  logic [IDX_W-1:0]    pos_i,
  input  logic [IDX_W-1:0]    tgt_i,
  output logic                tok_vld_o,
  output tts_pkg::tts_token_t tok_o,
  output logic [IDX_W-1:0]    pos_o,
  output logic [IDX_W-1:0]    tgt_o
);

  localparam int EW = (IDX_W > tts_pkg::SLOT_W) ? IDX_W : tts_pkg::SLOT_W;

  logic                        live_r, live_nxt;
  logic                        zombie_r, zombie_nxt;
  logic                        blocked_r, blocked_nxt;
  logic [tts_pkg::RUNS_W-1:0]  pend_r, pend_nxt;
  logic [tts_pkg::CNT_W-1:0]   busy_r, busy_nxt;
  logic [tts_pkg::TK_W-1:0]    period_r, period_nxt;
  logic [tts_pkg::TK_W-1:0]    rem_r, rem_nxt;
  logic [tts_pkg::CNT_W-1:0]   start_r, start_nxt;

  logic                        tok_vld_r;
  tts_pkg::tts_token_t         tok_r, tok_nxt;
  logic [IDX_W-1:0]            pos_r, tgt_r;

  logic                        hit;
  logic [EW-1:0]               pos_ext;

  assign hit     = tok_i.tgt_vld && (tgt_i == pos_i);
  assign pos_ext = EW'(pos_i);

  always_comb begin
    live_nxt    = live_r;
    zombie_nxt  = zombie_r;
    blocked_nxt = blocked_r;
    pend_nxt    = pend_r;
    busy_nxt    = busy_r;
    period_nxt  = period_r;
    rem_nxt     = rem_r;
    start_nxt   = start_r;
    tok_nxt     = tok_i;
    if (tok_vld_i) begin
      case (tok_i.mode)
        tts_pkg::MODE_CREATE: begin
          if (!live_r && !tok_i.claimed) begin
            live_nxt        = 1'b1;
            zombie_nxt      = 1'b0;
            blocked_nxt     = 1'b0;
            pend_nxt        = '0;
            busy_nxt        = '0;
            period_nxt      = tok_i.period_tk;
            rem_nxt         = tok_i.delay_tk;
            tok_nxt.claimed = 1'b1;
            tok_nxt.ok      = 1'b1;
            tok_nxt.slot    = pos_ext[tts_pkg::SLOT_W-1:0];
          end
        end
        tts_pkg::MODE_KILL: begin
          if (hit) begin
            live_nxt = 1'b0;
          end
        end
        tts_pkg::MODE_TICK: begin
          if (live_r && !zombie_r) begin
            if (rem_r != '0) begin
              rem_nxt = rem_r - 1'b1;
            end else begin
              if (pend_r != tts_pkg::RUNS_MAX) begin
                pend_nxt = pend_r + 1'b1;
              end
              if (period_r != '0) begin
                rem_nxt = period_r - 1'b1;
              end else begin
                zombie_nxt = 1'b1;
              end
            end
          end
        end
        tts_pkg::MODE_DISPATCH: begin
          if (hit && live_r && !blocked_r && (pend_r != '0)) begin
            blocked_nxt = 1'b1;
            start_nxt   = tok_i.tick_count;
            tok_nxt.ok  = 1'b1;
          end
        end
        tts_pkg::MODE_FINISH: begin
          if (hit) begin
            if (blocked_r) begin
              blocked_nxt = 1'b0;
              if (pend_r != '0) begin
                pend_nxt = pend_r - 1'b1;
              end
              busy_nxt = busy_r + (tok_i.tick_count - start_r) + 32'd1;
              if (zombie_r) begin
                live_nxt = 1'b0;
              end
            end
            tok_nxt.busy = busy_nxt;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r    <= 1'b0;
      zombie_r  <= 1'b0;
      blocked_r <= 1'b0;
      pend_r    <= '0;
      busy_r    <= '0;
      tok_vld_r <= 1'b0;
    end else begin
      live_r    <= live_nxt;
      zombie_r  <= zombie_nxt;
      blocked_r <= blocked_nxt;
      pend_r    <= pend_nxt;
      busy_r    <= busy_nxt;
      tok_vld_r <= tok_vld_i;
    end
  end

  always_ff @(posedge clk) begin
    period_r <= period_nxt;
    rem_r    <= rem_nxt;
    start_r  <= start_nxt;
    tok_r    <= tok_nxt;
    pos_r    <= pos_i + 1'b1;
    tgt_r    <= tgt_i;
  end

  assign tok_vld_o = tok_vld_r;
  assign tok_o     = tok_r;
  assign pos_o     = pos_r;
  assign tgt_o     = tgt_r;

endmodule

/* rtl/time_triggered_task_scheduler.sv */
// ----------------------------------------------------------------------------
// time_triggered_task_scheduler
// Periodic task table: create, kill, tick, dispatch and finish commands run
// as a token through a row of slot cells, one cell per cycle.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_ready    mode, task_slot, period_ms, delay_ms
//  out_     output     out_valid / out_ready  ok, slot, tick_count, busy_ticks
//
// A beat runs from accept through the conversion stage, the launch register
// and the TASKS slot cells into the output register.
// A new beat is accepted as soon as the previous token has left the chain,
// even while its result still waits in the output register; the new token
// holds in the conversion stage until that register is empty.
// Reset clears the whole table of live, zombie, blocked, pending and busy
// state at once; no clearing pass is needed.
//
module time_triggered_task_scheduler #(
  parameter int TASKS   = tts_pkg::TASKS_DEF,
  parameter int TICK_MS = tts_pkg::TICK_MS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [tts_pkg::MODE_W-1:0] in_mode,
  input  logic [tts_pkg::SLOT_W-1:0] in_task_slot,
  input  logic [tts_pkg::MS_W-1:0]   in_period_ms,
  input  logic [tts_pkg::MS_W-1:0]   in_delay_ms,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_ok,
  output logic [tts_pkg::SLOT_W-1:0] out_slot,
  output logic [tts_pkg::CNT_W-1:0]  out_tick_count,
  output logic [tts_pkg::CNT_W-1:0]  out_busy_ticks
);

  localparam int IDX_W = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int EW    = (IDX_W > tts_pkg::SLOT_W) ? IDX_W : tts_pkg::SLOT_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,   // waiting for a beat
    ST_CONV = 3'b010,   // beat held, ticks converted, waiting to launch
    ST_RUN  = 3'b100    // token walking the cells
  } state_t;

  state_t                       state_r, state_nxt;

  // Captured input beat
  logic [tts_pkg::MODE_W-1:0]   mode_r;
  logic [tts_pkg::SLOT_W-1:0]   task_slot_r;
  logic [tts_pkg::MS_W-1:0]     period_ms_r;
  logic [tts_pkg::MS_W-1:0]     delay_ms_r;

  // Global scheduler state
  logic [IDX_W-1:0]             next_slot_r, next_slot_nxt;
  logic [tts_pkg::CNT_W-1:0]    tick_cnt_r, tick_cnt_nxt;

  // Output register
  logic                         out_valid_r;
  tts_pkg::tts_token_t          out_tok_r;

  // Launch register and cell chain
  logic                         launch;
  logic                         accept;
  logic                         chain_exit;
  logic [TASKS:0]               chain_vld;
  tts_pkg::tts_token_t          chain_tok [0:TASKS];
  logic [IDX_W-1:0]             chain_pos [0:TASKS];
  logic [IDX_W-1:0]             chain_tgt [0:TASKS];
  logic                         vld0_r;
  tts_pkg::tts_token_t          tok0_r, tok0_nxt;
  logic [IDX_W-1:0]             tgt0_r, tgt0_nxt;

  logic [tts_pkg::TK_W-1:0]     period_tk;
  logic [tts_pkg::TK_W-1:0]     delay_tk;
  logic [EW-1:0]                ts_ext;
  logic [EW-1:0]                ns_ext;
  logic                         ts_in_range;

  assign accept     = in_valid && in_ready;
  assign in_ready   = (state_r == ST_IDLE);
  // Launch only into an empty output register: nothing else can fill it
  // before this token comes out of the chain.
  assign launch     = (state_r == ST_CONV) && !out_valid_r;
  assign chain_exit = chain_vld[TASKS];

  tts_tick_conv #(
    .TICK_MS (TICK_MS)
  ) u_conv_period (
    .ms    (period_ms_r),
    .ticks (period_tk)
  );

  tts_tick_conv #(
    .TICK_MS (TICK_MS)
  ) u_conv_delay (
    .ms    (delay_ms_r),
    .ticks (delay_tk)
  );

  assign ts_ext      = EW'(task_slot_r);
  assign ns_ext      = EW'(next_slot_r);
  assign ts_in_range = {1'b0, ts_ext} < (EW + 1)'(TASKS);

  // Build the token: targets, reported slot and the tick count after this beat
  always_comb begin
    tok0_nxt            = tok0_r;
    tgt0_nxt            = tgt0_r;
    next_slot_nxt       = next_slot_r;
    tick_cnt_nxt        = tick_cnt_r;
    if (launch) begin
      tok0_nxt.mode       = mode_r;
      tok0_nxt.tgt_vld    = 1'b0;
      tok0_nxt.period_tk  = period_tk;
      tok0_nxt.delay_tk   = delay_tk;
      tok0_nxt.claimed    = 1'b0;
      tok0_nxt.ok         = 1'b0;
      tok0_nxt.slot       = '0;
      tok0_nxt.tick_count = tick_cnt_r;
      tok0_nxt.busy       = '0;
      tgt0_nxt            = ts_ext[IDX_W-1:0];
      case (mode_r)
        tts_pkg::MODE_KILL,
        tts_pkg::MODE_FINISH: begin
          tok0_nxt.tgt_vld = ts_in_range;
          tok0_nxt.slot    = task_slot_r;
        end
        tts_pkg::MODE_TICK: begin
          tick_cnt_nxt        = tick_cnt_r + 32'd1;
          tok0_nxt.tick_count = tick_cnt_nxt;
        end
        tts_pkg::MODE_DISPATCH: begin
          tok0_nxt.tgt_vld = 1'b1;
          tok0_nxt.slot    = ns_ext[tts_pkg::SLOT_W-1:0];
          tgt0_nxt         = next_slot_r;
          // Advance round robin, wrapping at the table size
          if (next_slot_r == IDX_W'(TASKS - 1)) begin
            next_slot_nxt = '0;
          end else begin
            next_slot_nxt = next_slot_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        if (launch) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (chain_exit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_slot_r <= '0;
      tick_cnt_r  <= '0;
      vld0_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_slot_r <= next_slot_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      vld0_r      <= launch;
      // Load on exit, drop once the beat is taken
      if (chain_exit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r      <= in_mode;
      task_slot_r <= in_task_slot;
      period_ms_r <= in_period_ms;
      delay_ms_r  <= in_delay_ms;
    end
    tok0_r <= tok0_nxt;
    tgt0_r <= tgt0_nxt;
    if (chain_exit) begin
      out_tok_r <= chain_tok[TASKS];
    end
  end

  assign chain_vld[0] = vld0_r;
  assign chain_tok[0] = tok0_r;
  assign chain_pos[0] = '0;
  assign chain_tgt[0] = tgt0_r;

  // Row of slot cells; cell k owns slot k and sees the token at step k
  for (genvar k = 0; k < TASKS; k++) begin : g_cell
    tts_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .tok_vld_i (chain_vld[k]),
      .tok_i     (chain_tok[k]),
      .pos_i     (chain_pos[k]),
      .tgt_i     (chain_tgt[k]),
      .tok_vld_o (chain_vld[k+1]),
      .tok_o     (chain_tok[k+1]),
      .pos_o     (chain_pos[k+1]),
      .tgt_o     (chain_tgt[k+1])
    );
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_tok_r.ok;
  assign out_slot       = out_tok_r.slot;
  assign out_tick_count = out_tok_r.tick_count;
  assign out_busy_ticks = out_tok_r.busy;

  // Never more than one token in the chain
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(chain_vld) <= 1)
    else $error("more than one token in the cell chain");

  // While running, the token is somewhere in the chain; otherwise it is empty
  a_run_token: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ($countones(chain_vld) == 1))
    else $error("running without a token in the chain");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_RUN) |-> (chain_vld == '0))
    else $error("token in the chain outside the run state");

  // A token leaving the chain always finds the output register free
  a_exit_free: assert property (@(posedge clk) disable iff (!rst_n)
    chain_exit |-> !out_valid_r)
    else $error("result overwrites a pending output beat");

  // Round robin pointer stays inside the table
  a_next_slot: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, next_slot_r} <= (IDX_W + 1)'(TASKS - 1))
    else $error("round robin pointer out of range");

endmodule
